FILE: rtl/core/dba_pkg.sv
// dba_pkg: shared constants for the disk block allocator
// field widths, command and status codes, parameter defaults; no dependencies
package dba_pkg;

  // parameter defaults
  localparam int unsigned NUM_BLOCKS_DEF  = 64;
  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned ID_WIDTH_DEF    = 8;

  // fixed field widths
  localparam int unsigned CMD_W     = 1;
  localparam int unsigned FILE_ID_W = 8;
  localparam int unsigned SIZE_W    = 20;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 7;

  // active block count after reset
  localparam logic [COUNT_W-1:0] ACTIVE_RESET = 7'd64;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

FILE: rtl/core/dba_ram.sv
// dba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dba_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/disk_block_allocator.sv
// disk_block_allocator: first-fit block allocation bitmap with owner ids
// depends on dba_pkg and dba_ram
//
// usage:
// - input channel (in_valid_i / in_ready_o) carries one transaction: cmd_i
//   (insert or remove), file_id_i and size_bytes_i (insert only)
// - output channel (out_valid_o / out_ready_i) returns one transaction per
//   input: status_o, blocks_changed_o, free_count_o
// - config channel (cfg_valid_i / cfg_ready_o, cfg_data_i) sets the number of
//   active blocks; always ready, write only while no transaction is in flight
// - per block the used bit and owner id live in one ram word; every transaction
//   walks the active range through the ram's single read port, one entry a
//   cycle, and writes changed entries back through the write port
// - insert: a counting pass, then (if there is room) an allocation pass; with
//   no space the result follows the counting pass alone
// - remove: one pass freeing matching blocks
// - one transaction at a time, the next accepted the cycle after the result is
//   loaded; a stalled result waits in the output register while the next one
//   runs and holds in its final state until the output register frees
// - reset: used bits are cleared by a pass over all NUM_BLOCKS ram words,
//   during which no input transaction is accepted; the
//   active count resets to 64
module disk_block_allocator #(
  parameter int unsigned NUM_BLOCKS  = dba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = dba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned ID_WIDTH    = dba_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input transactions
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dba_pkg::CMD_W-1:0]      cmd_i,
  input  logic [dba_pkg::FILE_ID_W-1:0]  file_id_i,
  input  logic [dba_pkg::SIZE_W-1:0]     size_bytes_i,
  // result transactions
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dba_pkg::STATUS_W-1:0]   status_o,
  output logic [dba_pkg::COUNT_W-1:0]    blocks_changed_o,
  output logic [dba_pkg::COUNT_W-1:0]    free_count_o,
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dba_pkg::COUNT_W-1:0]    cfg_data_i
);

  // ram index and block count widths
  localparam int unsigned IDX_W   = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CMP_W   = (CNT_W > dba_pkg::COUNT_W) ? CNT_W : dba_pkg::COUNT_W;
  // byte totals: up to NUM_BLOCKS * BLOCK_BYTES, compared against a size
  localparam int unsigned BYTES_W = CNT_W + $clog2(BLOCK_BYTES + 1);
  localparam int unsigned ACC_W   = (BYTES_W > dba_pkg::SIZE_W) ? BYTES_W : dba_pkg::SIZE_W;
  localparam int unsigned EXT_W   = CNT_W + dba_pkg::COUNT_W;
  localparam int unsigned IDX_EXT = ID_WIDTH + dba_pkg::FILE_ID_W;
  localparam int unsigned WORD_W  = ID_WIDTH + 1;

  localparam logic [ACC_W-1:0] BlkBytes = ACC_W'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0] LastIdx  = CNT_W'(NUM_BLOCKS - 1);
  localparam logic [CMP_W-1:0] NumBlk   = CMP_W'(NUM_BLOCKS);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_COUNT  = 5'b00100,
    ST_APPLY  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [dba_pkg::COUNT_W-1:0] active_q;

  // current transaction
  logic [dba_pkg::CMD_W-1:0]   cmd_q;
  logic [ID_WIDTH-1:0]         id_q;
  logic [dba_pkg::SIZE_W-1:0]  size_q;
  logic [CNT_W-1:0]            lim_q;

  // scan pointer, read pipeline, counters
  logic [CNT_W-1:0]  ra_q, ra_d;
  logic              rvalid_q, rvalid_d;
  logic [IDX_W-1:0]  ridx_q;
  logic [ACC_W-1:0]  bytes_q, bytes_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  chg_q, chg_d;

  // output register
  logic                           out_valid_q;
  logic [dba_pkg::STATUS_W-1:0]   status_q;
  logic [dba_pkg::COUNT_W-1:0]    changed_q;
  logic [dba_pkg::COUNT_W-1:0]    free_out_q;

  // ram ports
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              rd_en;
  logic [WORD_W-1:0] mem_rdata;
  logic              rd_used;
  logic [ID_WIDTH-1:0] rd_owner;

  // derived values
  logic [CMP_W-1:0]   active_ext;
  logic [CNT_W-1:0]   lim;
  logic [IDX_EXT-1:0] id_ext;
  logic [ACC_W-1:0]   size_ext;
  logic               in_accept;
  logic               load_out;
  logic               pass_done;
  logic [CNT_W-1:0]   free_after;
  logic [EXT_W-1:0]   free_after_ext;
  logic [EXT_W-1:0]   chg_ext;
  logic [dba_pkg::STATUS_W-1:0] status_n;

  // active range, saturated to the ram depth
  assign active_ext = CMP_W'(active_q);
  assign lim        = (active_ext > NumBlk) ? CNT_W'(NUM_BLOCKS) : CNT_W'(active_ext);

  // file id reduced or widened to ID_WIDTH bits
  assign id_ext   = IDX_EXT'(file_id_i);
  assign size_ext = ACC_W'(size_q);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign rd_used  = mem_rdata[ID_WIDTH];
  assign rd_owner = mem_rdata[ID_WIDTH-1:0];

  // one read a cycle while the pointer is inside the active range
  assign rd_en     = ((state_q == ST_COUNT) || (state_q == ST_APPLY)) && (ra_q < lim_q);
  assign pass_done = !rd_en && !rvalid_q;

  // result fields
  assign free_after = (cmd_q == dba_pkg::CMD_INSERT) ? (free_q - chg_q) : (free_q + chg_q);
  assign free_after_ext = EXT_W'(free_after);
  assign chg_ext        = EXT_W'(chg_q);

  always_comb begin
    if (cmd_q == dba_pkg::CMD_INSERT) begin
      status_n = (chg_q == '0) ? dba_pkg::ST_NOSPACE : dba_pkg::ST_STORED;
    end else begin
      status_n = (chg_q == '0) ? dba_pkg::ST_NOTFOUND : dba_pkg::ST_REMOVED;
    end
  end

  // sequencer: clear pass, count pass, read-modify-write pass
  always_comb begin
    state_d   = state_q;
    ra_d      = ra_q;
    rvalid_d  = rd_en;
    bytes_d   = bytes_q;
    free_d    = free_q;
    chg_d     = chg_q;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ridx_q;
    mem_wdata = '0;

    if (rd_en) begin
      ra_d = ra_q + CNT_W'(1);
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ra_q[IDX_W-1:0];
        mem_wdata = '0;
        ra_d      = ra_q + CNT_W'(1);
        if (ra_q == LastIdx) begin
          ra_d    = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          ra_d    = '0;
          bytes_d = '0;
          free_d  = '0;
          chg_d   = '0;
          state_d = (cmd_i == dba_pkg::CMD_INSERT) ? ST_COUNT : ST_APPLY;
        end
      end

      ST_COUNT: begin
        // count free blocks and the bytes they hold
        if (rvalid_q && !rd_used) begin
          free_d  = free_q + CNT_W'(1);
          bytes_d = bytes_q + BlkBytes;
        end
        if (pass_done) begin
          ra_d    = '0;
          bytes_d = '0;
          // enough room when free * BLOCK_BYTES > size
          state_d = (bytes_q > size_ext) ? ST_APPLY : ST_FINISH;
        end
      end

      ST_APPLY: begin
        if (rvalid_q) begin
          if (cmd_q == dba_pkg::CMD_INSERT) begin
            // allocate while chg * BLOCK_BYTES <= size
            if (!rd_used && (bytes_q <= size_ext)) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, id_q};
              chg_d     = chg_q + CNT_W'(1);
              bytes_d   = bytes_q + BlkBytes;
            end
          end else begin
            if (rd_used && (rd_owner == id_q)) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b0, rd_owner};
              chg_d     = chg_q + CNT_W'(1);
            end
            if (!rd_used) begin
              free_d = free_q + CNT_W'(1);
            end
          end
        end
        if (pass_done) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      active_q    <= dba_pkg::ACTIVE_RESET;
      ra_q        <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ra_q     <= ra_d;
      rvalid_q <= rvalid_d;
      if (cfg_valid_i) begin
        active_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    ridx_q  <= ra_q[IDX_W-1:0];
    bytes_q <= bytes_d;
    free_q  <= free_d;
    chg_q   <= chg_d;
    if (in_accept) begin
      cmd_q  <= cmd_i;
      id_q   <= id_ext[ID_WIDTH-1:0];
      size_q <= size_bytes_i;
      lim_q  <= lim;
    end
    if (load_out) begin
      status_q   <= status_n;
      changed_q  <= chg_ext[dba_pkg::COUNT_W-1:0];
      free_out_q <= free_after_ext[dba_pkg::COUNT_W-1:0];
    end
  end

  // used bit and owner id, one word per block
  dba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_BLOCKS)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (ra_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign blocks_changed_o = changed_q;
  assign free_count_o     = free_out_q;

endmodule
